FILE: sv/rtcoff_pkg.sv
// ----------------------------------------------------------------------------
// rtcoff_pkg
// Shared types and constants for the RTC offset register access block:
// register codes, sequencer states, divider pass setup and field helpers.
// ----------------------------------------------------------------------------
package rtcoff_pkg;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [3:0] REG_SEC     = 4'd8;
	localparam logic [3:0] REG_MIN     = 4'd9;
	localparam logic [3:0] REG_HOUR    = 4'd10;
	localparam logic [3:0] REG_DAY_LO  = 4'd11;
	localparam logic [3:0] REG_DAY_HI  = 4'd12;

	localparam logic [31:0] SECS_PER_MIN  = 32'd60;
	localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
	localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
	localparam logic [31:0] SECS_PER_256D = 32'd22118400;

	// Divider passes: elapsed/60, minutes/60, hours/24 (two quotient bits per cycle)
	localparam logic [5:0] DIV_SIXTY     = 6'd60;
	localparam logic [5:0] DIV_TWENTYFOUR = 6'd24;
	localparam int         PASS0_BITS    = 32;
	localparam int         PASS1_BITS    = 28;
	localparam int         PASS2_BITS    = 22;
	localparam logic [4:0] PASS0_PAIRS   = 5'(PASS0_BITS / 2);
	localparam logic [4:0] PASS1_PAIRS   = 5'(PASS1_BITS / 2);
	localparam logic [4:0] PASS2_PAIRS   = 5'(PASS2_BITS / 2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PASS_SEC,
		PASS_MIN,
		PASS_HOUR
	} pass_t;

	typedef struct packed {
		logic       load;
		logic [5:0] divisor;
		logic [4:0] pairs;
	} div_ctl_t;

	// Byte modulo 60 by binary reduction
	function automatic logic [5:0] mod60_byte(input logic [7:0] d);
		logic [7:0] v;
		v = d;
		if (v >= 8'd240) v = v - 8'd240;
		if (v >= 8'd120) v = v - 8'd120;
		if (v >= 8'd60)  v = v - 8'd60;
		return v[5:0];
	endfunction

	// Byte modulo 24 by binary reduction
	function automatic logic [4:0] mod24_byte(input logic [7:0] d);
		logic [7:0] v;
		v = d;
		if (v >= 8'd192) v = v - 8'd192;
		if (v >= 8'd96)  v = v - 8'd96;
		if (v >= 8'd48)  v = v - 8'd48;
		if (v >= 8'd24)  v = v - 8'd24;
		return v[4:0];
	endfunction

endpackage

FILE: sv/rtcoff_div.sv
// ----------------------------------------------------------------------------
// rtcoff_div
// Shared restoring divider by a small constant divisor, two quotient bits
// per cycle. The dividend is loaded left-aligned; after the programmed
// number of steps the quotient sits in the low bits and fin pulses.
// ----------------------------------------------------------------------------
module rtcoff_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtcoff_pkg::div_ctl_t ctl,
	input  logic [31:0]          dividend,
	output logic [31:0]          quotient,
	output logic [5:0]           remainder,
	output logic                 fin
);
	import rtcoff_pkg::*;

	logic [31:0] quo_q;
	logic [5:0]  rem_q;
	logic [5:0]  div_q;
	logic [4:0]  cnt_q;
	logic        fin_q;

	logic [6:0]  t1, t2;
	logic [5:0]  r1;
	logic        b1, b2;

	always_comb begin
		t1 = {rem_q, quo_q[31]};
		b1 = (t1 >= {1'b0, div_q});
		r1 = b1 ? 6'(t1 - {1'b0, div_q}) : t1[5:0];
		t2 = {r1, quo_q[30]};
		b2 = (t2 >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else begin
			fin_q <= (cnt_q == 5'd1) && !ctl.load;
			if (ctl.load) begin
				cnt_q <= ctl.pairs;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= ctl.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[29:0], b1, b2};
			rem_q <= b2 ? 6'(t2 - {1'b0, div_q}) : t2[5:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign fin       = fin_q;

endmodule

FILE: sv/rtc_offset_register_access.sv
// ----------------------------------------------------------------------------
// rtc_offset_register_access
// Emulated cartridge clock registers kept as one 32-bit offset from host time.
// Reads split elapsed time into a field; writes splice a field and move the
// offset.
// ----------------------------------------------------------------------------
//  channel   ports                                               timing
//  command   start, busy, operation, register_select,            start && !busy
//            write_data, host_seconds
//  result    done, read_data                                     one-cycle strobe
//
// From the accepting edge to the done strobe each access makes three passes
// through the shared two-bit-per-cycle divider (elapsed/60, minutes/60,
// hours/24), then goes through a multiply state and an update state.
// busy is high from the accepting edge until the cycle of the strobe; a new
// command may be accepted at the edge that ends the strobe.
// Reset clears the offset to zero and returns the sequencer to idle.
// The receiver cannot stall: each result is transferred in its strobe cycle.
// ----------------------------------------------------------------------------
module rtc_offset_register_access (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [3:0]  register_select,
	input  logic [7:0]  write_data,
	input  logic [31:0] host_seconds,
	output logic        done,
	output logic [7:0]  read_data
);
	import rtcoff_pkg::*;

	state_t      state_q, state_d;
	pass_t       pass_q, pass_d;
	logic [31:0] offset_q;
	logic        op_q;
	logic [3:0]  sel_q;
	logic [7:0]  data_q;
	logic [5:0]  sec_q, min_q;
	logic [4:0]  hour_q;
	logic [15:0] day_q;
	logic [31:0] prod_q;
	logic        done_q;
	logic [7:0]  rdata_q;

	div_ctl_t    div_ctl;
	logic [31:0] div_dividend;
	logic [31:0] div_quo;
	logic [5:0]  div_rem;
	logic        div_fin;

	logic        accept;
	logic [31:0] delta;
	logic [31:0] weight;
	logic [7:0]  rd_field;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	rtcoff_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dividend),
		.quotient  (div_quo),
		.remainder (div_rem),
		.fin       (div_fin)
	);

	// Sequencer: next state and divider pass loads
	always_comb begin
		state_d      = state_q;
		pass_d       = pass_q;
		div_ctl      = '0;
		div_dividend = host_seconds - offset_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					div_ctl = '{load: 1'b1, divisor: DIV_SIXTY, pairs: PASS0_PAIRS};
					pass_d  = PASS_SEC;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_fin) begin
					case (pass_q)
						PASS_SEC: begin
							div_ctl      = '{load: 1'b1, divisor: DIV_SIXTY,
							                 pairs: PASS1_PAIRS};
							div_dividend = {div_quo[PASS1_BITS-1:0],
							                {(32-PASS1_BITS){1'b0}}};
							pass_d       = PASS_MIN;
						end
						PASS_MIN: begin
							div_ctl      = '{load: 1'b1, divisor: DIV_TWENTYFOUR,
							                 pairs: PASS2_PAIRS};
							div_dividend = {div_quo[PASS2_BITS-1:0],
							                {(32-PASS2_BITS){1'b0}}};
							pass_d       = PASS_HOUR;
						end
						default: begin
							state_d = ST_MUL;
						end
					endcase
				end
			end
			ST_MUL: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Field change times its weight in seconds; unknown registers move nothing
	always_comb begin
		delta  = '0;
		weight = '0;
		case (sel_q)
			REG_SEC: begin
				delta  = {26'd0, mod60_byte(data_q)} - {26'd0, sec_q};
				weight = 32'd1;
			end
			REG_MIN: begin
				delta  = {26'd0, mod60_byte(data_q)} - {26'd0, min_q};
				weight = SECS_PER_MIN;
			end
			REG_HOUR: begin
				delta  = {27'd0, mod24_byte(data_q)} - {27'd0, hour_q};
				weight = SECS_PER_HOUR;
			end
			REG_DAY_LO: begin
				delta  = {24'd0, data_q} - {24'd0, day_q[7:0]};
				weight = SECS_PER_DAY;
			end
			REG_DAY_HI: begin
				delta  = {31'd0, data_q[0]} - {24'd0, day_q[15:8]};
				weight = SECS_PER_256D;
			end
			default: begin
				delta  = '0;
				weight = '0;
			end
		endcase
	end

	always_comb begin
		case (sel_q)
			REG_SEC:    rd_field = {2'd0, sec_q};
			REG_MIN:    rd_field = {2'd0, min_q};
			REG_HOUR:   rd_field = {3'd0, hour_q};
			REG_DAY_LO: rd_field = day_q[7:0];
			REG_DAY_HI: rd_field = {7'd0, day_q[8]};
			default:    rd_field = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pass_q   <= PASS_SEC;
			offset_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			done_q  <= (state_q == ST_FIN);
			// new offset = host - (elapsed + change) = offset - change
			if (state_q == ST_FIN && op_q == OP_WRITE) begin
				offset_q <= offset_q - prod_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			sel_q  <= register_select;
			data_q <= write_data;
		end
		if (state_q == ST_DIV && div_fin) begin
			case (pass_q)
				PASS_SEC: sec_q <= div_rem;
				PASS_MIN: min_q <= div_rem;
				default: begin
					hour_q <= div_rem[4:0];
					day_q  <= div_quo[15:0];
				end
			endcase
		end
		if (state_q == ST_MUL) begin
			prod_q <= 32'(delta * weight);
		end
		if (state_q == ST_FIN) begin
			rdata_q <= (op_q == OP_WRITE) ? 8'd0 : rd_field;
		end
	end

	assign done      = done_q;
	assign read_data = rdata_q;

	// Checks
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("done strobe without update cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_offset_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(offset_q) |-> $past(state_q == ST_FIN && op_q == OP_WRITE))
		else $error("offset changed outside a write update");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (op_q == OP_READ || read_data == 8'd0))
		else $error("write returned nonzero data");

endmodule
